[rtl/core/tcpa_pkg.sv]
// shared types, constants and helpers for the three-channel pi controller
`timescale 1ns / 1ps

package tcpa_pkg;

  localparam int DIV_W   = 24;
  localparam int DEN_W   = 16;
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int SAT_W   = 28;
  localparam int DRIVE_W = 15;
  localparam int MAG_W   = 24;
  localparam int RCP_W   = 26;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INT_DIV    = 2'd1;
  localparam logic [1:0] REG_WINDUP     = 2'd2;

  localparam logic [7:0]  PROP_GAIN_RST = 8'd105;
  localparam logic [15:0] INT_DIV_RST   = 16'd360;
  localparam logic [7:0]  WINDUP_RST    = 8'd1;

  // divide by 100 as multiply by ceil(2^32 / 100), exact for magnitudes below 2^24
  localparam logic [RCP_W-1:0] SCALE_RECIP = 26'd42949673;
  localparam int               SCALE_SHIFT = 32;
  localparam logic signed [19:0] DRIVE_LIMIT = 20'sd10000;

  typedef struct packed {
    logic [7:0]  prop_gain;
    logic [15:0] integral_divisor;
    logic [7:0]  windup_gain;
  } cfg_t;

  typedef struct packed {
    logic               fin;
    logic [DRIVE_W-1:0] drive;
  } lane_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [15:0] r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/three_channel_pi_antiwindup.sv]
// top level: config registers, three controller lanes and the result register
// in_ready drops when an input transaction is accepted and returns when the result moves to the output register
// one item at a time, so the divider pass in each lane sets the throughput
// a finished result waits in the lanes until the output register is free
// reset: synchronous, restores gain 105, divisor 360, windup gain 1, clears state
`timescale 1ns / 1ps

module three_channel_pi_antiwindup (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [9:0]  setpoint_a,
  input  logic signed [9:0]  setpoint_b,
  input  logic signed [9:0]  setpoint_c,
  input  logic signed [15:0] measured_a,
  input  logic signed [15:0] measured_b,
  input  logic signed [15:0] measured_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] drive_a,
  output logic signed [14:0] drive_b,
  output logic signed [14:0] drive_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tcpa_pkg::*;

  typedef enum logic {T_IDLE, T_BUSY} tstate_t;

  tstate_t      state;
  cfg_t         cfg;
  lane_status_t st_a, st_b, st_c;
  logic         accept;
  logic         all_fin;
  logic         ack;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign all_fin   = st_a.fin && st_b.fin && st_c.fin;
  assign ack       = all_fin && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= PROP_GAIN_RST;
      cfg.integral_divisor <= INT_DIV_RST;
      cfg.windup_gain      <= WINDUP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN: cfg.prop_gain        <= cfg_data[7:0];
        REG_INT_DIV:   cfg.integral_divisor <= cfg_data;
        REG_WINDUP:    cfg.windup_gain      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tcpa_lane u_lane_a (
    .clk(clk), .rst(rst), .start(accept), .sp(setpoint_a), .meas(measured_a),
    .cfg(cfg), .ack(ack), .status(st_a)
  );

  tcpa_lane u_lane_b (
    .clk(clk), .rst(rst), .start(accept), .sp(setpoint_b), .meas(measured_b),
    .cfg(cfg), .ack(ack), .status(st_b)
  );

  tcpa_lane u_lane_c (
    .clk(clk), .rst(rst), .start(accept), .sp(setpoint_c), .meas(measured_c),
    .cfg(cfg), .ack(ack), .status(st_c)
  );

  // merge: collect all three lanes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ack) begin
        out_valid <= 1'b1;
        drive_a   <= st_a.drive;
        drive_b   <= st_b.drive;
        drive_c   <= st_c.drive;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            state <= T_BUSY;
          end
        end
        T_BUSY: begin
          if (ack) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tcpa_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tcpa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tcpa_pkg::DIV_W-1:0]  num,
  input  logic [tcpa_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [tcpa_pkg::DIV_W-1:0]  quo
);
  import tcpa_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

[rtl/core/tcpa_lane.sv]
// one controller channel: error, integral, scaled drive and clamp excess
`timescale 1ns / 1ps

module tcpa_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [9:0]      sp,
  input  logic signed [15:0]     meas,
  input  tcpa_pkg::cfg_t         cfg,
  input  logic                   ack,
  output tcpa_pkg::lane_status_t status
);
  import tcpa_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE, L_INT, L_SUM, L_ST1, L_DIV1, L_MUL, L_RCP, L_SCL, L_FIN
  } lstate_t;

  lstate_t state;

  logic signed [15:0] integral;
  logic signed [15:0] excess;
  logic signed [15:0] err;
  logic signed [24:0] wprod;
  logic signed [15:0] integ;
  logic signed [17:0] s;
  logic signed [25:0] prod;
  logic signed [19:0] raw;
  logic [MAG_W+RCP_W-1:0] rprod;

  logic signed [17:0] err_full;
  logic signed [26:0] integ_sum;
  logic        [16:0] integ_mag;
  logic [MAG_W-1:0]   prod_mag;
  logic signed [17:0] q1;
  logic signed [17:0] s_next;
  logic signed [19:0] raw_next;
  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic signed [15:0] excess_next;
  logic [DRIVE_W-1:0] drive;

  assign err_full  = {{8{sp[9]}}, sp} * 18'sd100 - {{2{meas[15]}}, meas};
  assign integ_sum = {{11{integral[15]}}, integral} + {{11{err[15]}}, err}
                     - {{2{wprod[24]}}, wprod};
  assign integ_mag = integ[15] ? 17'(-{integ[15], integ}) : {1'b0, integ};
  assign prod_mag  = prod[25] ? MAG_W'(-prod) : prod[MAG_W-1:0];

  assign q1       = integ[15] ? -{1'b0, div_quo[16:0]} : {1'b0, div_quo[16:0]};
  assign s_next   = {{2{err[15]}}, err} + q1;
  assign raw_next = prod[25] ? -{2'b0, rprod[MAG_W+RCP_W-1:SCALE_SHIFT]} :
                    {2'b0, rprod[MAG_W+RCP_W-1:SCALE_SHIFT]};

  assign div_start = (state == L_ST1);
  assign div_num   = DIV_W'(integ_mag);
  assign div_den   = (cfg.integral_divisor == '0) ? 16'd1 : cfg.integral_divisor;

  tcpa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (raw > DRIVE_LIMIT) begin
      drive       = DRIVE_W'(DRIVE_LIMIT);
      excess_next = sat16(SAT_W'(raw - DRIVE_LIMIT));
    end else if (raw < -DRIVE_LIMIT) begin
      drive       = DRIVE_W'(-DRIVE_LIMIT);
      excess_next = sat16(SAT_W'(raw + DRIVE_LIMIT));
    end else begin
      drive       = raw[DRIVE_W-1:0];
      excess_next = '0;
    end
  end

  assign status.fin   = (state == L_FIN);
  assign status.drive = drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      integral <= '0;
      excess   <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            err   <= sat16(SAT_W'(err_full));
            state <= L_INT;
          end
        end
        L_INT: begin
          wprod <= $signed({1'b0, cfg.windup_gain}) * excess;
          state <= L_SUM;
        end
        L_SUM: begin
          integ    <= sat16(SAT_W'(integ_sum));
          integral <= sat16(SAT_W'(integ_sum));
          state    <= L_ST1;
        end
        L_ST1: state <= L_DIV1;
        L_DIV1: begin
          if (div_done) begin
            s     <= s_next;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= $signed({1'b0, cfg.prop_gain}) * s;
          state <= L_RCP;
        end
        L_RCP: begin
          rprod <= prod_mag * SCALE_RECIP;
          state <= L_SCL;
        end
        L_SCL: begin
          raw   <= raw_next;
          state <= L_FIN;
        end
        L_FIN: begin
          if (ack) begin
            excess <= excess_next;
            state  <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tcpa_check.sv]
// port-level checks for the three-channel pi controller, bound to the top level
`timescale 1ns / 1ps

module tcpa_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] drive_a,
  input logic signed [14:0] drive_b,
  input logic signed [14:0] drive_c
);

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one item at a time: an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // drive commands stay within the clamp
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_a <= 15'sd10000) && (drive_a >= -15'sd10000) &&
                  (drive_b <= 15'sd10000) && (drive_b >= -15'sd10000) &&
                  (drive_c <= 15'sd10000) && (drive_c >= -15'sd10000))
    else $error("drive outside clamp");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_a) &&
                                $stable(drive_b) && $stable(drive_c))
    else $error("stalled result changed");

endmodule

bind three_channel_pi_antiwindup tcpa_check u_tcpa_check (.*);

[tb/sv/tb_three_channel_pi_antiwindup.sv]
// testbench for the three-channel pi controller: random and directed ticks checked against a predictor
`timescale 1ns / 1ps

module tb_three_channel_pi_antiwindup;
  import tcpa_pkg::*;

  localparam int          SETPOINT_SCALE = 100;
  localparam int          DRIVE_MAX      = 10000;
  localparam logic [1:0]  REG_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 64;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] a;
    logic signed [DRIVE_W-1:0] b;
    logic signed [DRIVE_W-1:0] c;
  } drive_trio_t;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_HALT} drain_mode_t;

  class drive_scoreboard;
    logic [7:0]  gain;
    logic [15:0] divisor;
    logic [7:0]  windup;
    longint      integ[3];
    longint      excess[3];
    drive_trio_t pending_drives[$];
    int          errors;

    function new();
      gain    = PROP_GAIN_RST;
      divisor = INT_DIV_RST;
      windup  = WINDUP_RST;
      errors  = 0;
      for (int i = 0; i < 3; i++) begin
        integ[i]  = 0;
        excess[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_PROP_GAIN: gain = data[7:0];
        REG_INT_DIV:   divisor = data;
        REG_WINDUP:    windup = data[7:0];
        default: ;
      endcase
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function logic signed [DRIVE_W-1:0] predict_lane(int ch, logic signed [9:0] sp,
                                                     logic signed [15:0] meas);
      longint err, acc, raw, div;
      err = clip16(longint'(sp) * SETPOINT_SCALE - longint'(meas));
      div = (divisor == 16'd0) ? 1 : longint'(divisor);
      acc = clip16(integ[ch] + err - longint'(windup) * excess[ch]);
      integ[ch] = acc;
      raw = longint'(gain) * (err + acc / div) / SETPOINT_SCALE;
      if (raw > DRIVE_MAX) begin
        excess[ch] = clip16(raw - DRIVE_MAX);
        return DRIVE_W'(DRIVE_MAX);
      end
      if (raw < -DRIVE_MAX) begin
        excess[ch] = clip16(raw + DRIVE_MAX);
        return DRIVE_W'(-DRIVE_MAX);
      end
      excess[ch] = 0;
      return DRIVE_W'(raw);
    endfunction

    function void note_input(logic signed [9:0] sa, logic signed [9:0] sb,
                             logic signed [9:0] sc, logic signed [15:0] ma,
                             logic signed [15:0] mb, logic signed [15:0] mc);
      drive_trio_t exp_drive;
      exp_drive.a = predict_lane(0, sa, ma);
      exp_drive.b = predict_lane(1, sb, mb);
      exp_drive.c = predict_lane(2, sc, mc);
      pending_drives.push_back(exp_drive);
    endfunction

    function void check_result(logic signed [DRIVE_W-1:0] da, logic signed [DRIVE_W-1:0] db,
                               logic signed [DRIVE_W-1:0] dc);
      drive_trio_t exp_drive;
      if (pending_drives.size() == 0) begin
        $error("drive transaction with nothing expected: %0d %0d %0d", da, db, dc);
        errors++;
        return;
      end
      exp_drive = pending_drives.pop_front();
      if (da !== exp_drive.a) begin
        $error("drive_a: expected %0d, got %0d", exp_drive.a, da);
        errors++;
      end
      if (db !== exp_drive.b) begin
        $error("drive_b: expected %0d, got %0d", exp_drive.b, db);
        errors++;
      end
      if (dc !== exp_drive.c) begin
        $error("drive_c: expected %0d, got %0d", exp_drive.c, dc);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [9:0]  setpoint_a;
  logic signed [9:0]  setpoint_b;
  logic signed [9:0]  setpoint_c;
  logic signed [15:0] measured_a;
  logic signed [15:0] measured_b;
  logic signed [15:0] measured_c;
  logic               out_valid;
  logic               out_ready;
  logic signed [14:0] drive_a;
  logic signed [14:0] drive_b;
  logic signed [14:0] drive_c;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  drive_scoreboard board;
  bit              hold_req;
  int unsigned     cycle_count;

  three_channel_pi_antiwindup u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .setpoint_a (setpoint_a),
    .setpoint_b (setpoint_b),
    .setpoint_c (setpoint_c),
    .measured_a (measured_a),
    .measured_b (measured_b),
    .measured_c (measured_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive_a    (drive_a),
    .drive_b    (drive_b),
    .drive_c    (drive_c),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_input(setpoint_a, setpoint_b, setpoint_c, measured_a, measured_b, measured_c);
      end
      if (out_valid && out_ready) begin
        board.check_result(drive_a, drive_b, drive_c);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    drain_mode_t mode;
    int          seg_len;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = drain_mode_t'($urandom_range(0, 3));
        seg_len = $urandom_range(1, 60);
        repeat (seg_len) begin
          case (mode)
            DRAIN_FREE:   out_ready <= 1'b1;
            DRAIN_COIN:   out_ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
            default:      out_ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [7:0] pg, input logic [15:0] div,
                            input logic [7:0] wg, input bit poke_unused);
    @(posedge clk);
    while (board.pending_drives.size() != 0) @(posedge clk);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_PROP_GAIN, {8'($urandom), pg});
    write_reg(REG_INT_DIV, div);
    write_reg(REG_WINDUP, {8'($urandom), wg});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic signed [9:0] sp_a, input logic signed [9:0] sp_b,
                           input logic signed [9:0] sp_c, input logic signed [15:0] ms_a,
                           input logic signed [15:0] ms_b, input logic signed [15:0] ms_c);
    in_valid   <= 1'b1;
    setpoint_a <= sp_a;
    setpoint_b <= sp_b;
    setpoint_c <= sp_c;
    measured_a <= ms_a;
    measured_b <= ms_b;
    measured_c <= ms_c;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly near-tracking speeds, some fully random fields
  task automatic gen_lane(output logic signed [9:0] sp, output logic signed [15:0] meas);
    longint m;
    int     amp;
    if ($urandom_range(0, 9) < 3) begin
      sp   = 10'($urandom);
      meas = 16'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       amp = 20;
        1:       amp = 400;
        2:       amp = 4000;
        default: amp = 20000;
      endcase
      sp = 10'($urandom_range(0, 654) - 327);
      m  = longint'(sp) * SETPOINT_SCALE + $urandom_range(0, 2 * amp) - amp;
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      meas = 16'(m);
    end
  endtask

  task automatic run_random(input int count, input bit no_gaps);
    logic signed [9:0]  sp[3];
    logic signed [15:0] ms[3];
    int                 burst_left;
    int                 gap;
    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < count; n++) begin
      for (int ch = 0; ch < 3; ch++) gen_lane(sp[ch], ms[ch]);
      if (n == count / 3) hold_req = 1'b1;
      send_item(sp[0], sp[1], sp[2], ms[0], ms[1], ms[2]);
      burst_left--;
      if (burst_left == 0) begin
        gap = no_gaps ? 0 : $urandom_range(0, 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    board      = new();
    hold_req   = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    setpoint_a = '0;
    setpoint_b = '0;
    setpoint_c = '0;
    measured_a = '0;
    measured_b = '0;
    measured_c = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains: saturation of error, integral and excess, then unwinding
    send_item(0, 0, 0, 0, 0, 0);
    repeat (4) send_item(511, -512, 0, -32768, 32767, 0);
    send_item(327, -327, 327, 32700, -32700, 0);
    send_item(-327, 327, 0, 32767, -32768, 32767);
    repeat (2) send_item(0, 0, 0, 0, 0, 0);
    send_item(1, -1, 100, 100, -100, 10000);
    send_item(-512, 511, -1, 32767, -32768, -1);
    send_item(256, -256, 128, 25600, -25600, 12800);
    send_item(10, 0, -10, 0, 5000, -1000);
    in_valid <= 1'b0;

    // full gains, unit divisor: excess saturates and drives hard back-calculation
    set_config(8'd255, 16'd1, 8'd255, 1'b0);
    repeat (3) send_item(511, 511, -512, -32768, -32768, 32767);
    repeat (2) send_item(0, 0, 0, 0, 0, 0);
    repeat (2) send_item(-512, 0, 511, 32767, 0, -32768);
    in_valid <= 1'b0;
    run_random(150, 1'b0);

    set_config(8'd0, 16'd65535, 8'd0, 1'b0);
    run_random(100, 1'b0);

    // zero divisor behaves as one; write to the unused index is ignored
    set_config(8'd105, 16'd0, 8'd1, 1'b1);
    run_random(150, 1'b0);

    set_config(8'd255, 16'd65535, 8'd0, 1'b0);
    run_random(150, 1'b1);

    set_config(8'($urandom), 16'($urandom_range(1, 1000)), 8'($urandom_range(0, 8)), 1'b1);
    run_random(150, 1'b0);

    set_config(8'($urandom), 16'($urandom), 8'($urandom), 1'b0);
    run_random(150, 1'b0);

    set_config(8'd1, 16'd2, 8'd255, 1'b0);
    run_random(150, 1'b0);

    set_config(8'($urandom_range(50, 255)), 16'($urandom_range(1, 500)), 8'($urandom), 1'b1);
    run_random(150, 1'b0);

    @(posedge clk);
    while (board.pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
